[hdl/bgd_pkg.sv]
// ----------------------------------------------------------------------------
// Button gesture detector package
// Shared types, register indexes, reset values and widths for the button
// gesture detector.
// ----------------------------------------------------------------------------
`default_nettype none

package bgd_pkg;

    // Field widths
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned EVENT_W = 3;
    localparam int unsigned INDEX_W = 2;

    // Configuration register indexes
    localparam logic [INDEX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [INDEX_W-1:0] CFG_LONG_PRESS = 2'd1;
    localparam logic [INDEX_W-1:0] CFG_CLICK_GAP  = 2'd2;

    // Configuration reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [CFG_W-1:0] CLICK_GAP_RST  = 16'd300;

    // Click count limit, the count that ends a gesture early and the single click count
    localparam logic [CNT_W-1:0] CNT_MAX    = 8'd255;
    localparam logic [CNT_W-1:0] CNT_DOUBLE = 8'd2;
    localparam logic [CNT_W-1:0] CNT_SINGLE = 8'd1;

    // Gesture states
    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_DOWN     = 3'd1,
        ST_UP       = 3'd2,
        ST_COUNT    = 3'd3,
        ST_HELD     = 3'd4,
        ST_RELEASED = 3'd5
    } t_gest_state;

    // Reported events
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 3'd0,
        EV_CLICK     = 3'd1,
        EV_DOUBLE    = 3'd2,
        EV_LONG      = 3'd3,
        EV_LONG_REL  = 3'd4
    } t_gest_event;

    // Debounce result handed to the gesture machine
    typedef struct packed {
        logic pressed;
    } t_deb_status;

    // Gesture machine request back to the debouncer
    typedef struct packed {
        logic clear;
    } t_gest_ctl;

endpackage

`default_nettype wire

[hdl/button_gesture_detector_unit.sv]
// ----------------------------------------------------------------------------
// Button gesture detector
// Debounces polled button levels and reports click, double click, long press
// start and long press release events, one result word per poll word.
// ----------------------------------------------------------------------------
// Each poll word carries the raw button level and a millisecond timestamp and
// produces exactly one result word with the event code and the debounced
// level. A poll is taken every clock cycle while the skid register is empty:
// the debounce and gesture state update in the cycle of acceptance and the
// result lands in an output register, with a one-word skid register so the
// input can take one more word while the output is stalled. The user writes
// the three timing registers through the config port only while no poll is in
// flight (not enforced by the block); indexes beyond the last register are ignored.
`default_nettype none

module button_gesture_detector_unit (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // Poll words
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [39:0]  s_axis_tdata,   // [0] pin_level, [32:1] time_ms, rest zero
    // Result words
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [7:0]   m_axis_tdata,   // [2:0] gesture_event, [3] stable_level, rest zero
    // Configuration writes
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [bgd_pkg::INDEX_W-1:0]       i_cfg_index,
    input  wire  [bgd_pkg::CFG_W-1:0]         i_cfg_data
);

    logic [bgd_pkg::CFG_W-1:0]   r_debounce_ms;
    logic [bgd_pkg::CFG_W-1:0]   r_long_press_ms;
    logic [bgd_pkg::CFG_W-1:0]   r_click_gap_ms;
    logic                        r_out_valid;
    logic [7:0]                  r_out_data;
    logic                        r_skid_valid;
    logic [7:0]                  r_skid_data;
    logic                        n_out_valid;
    logic [7:0]                  n_out_data;
    logic                        n_skid_valid;
    logic [7:0]                  n_skid_data;
    logic                        accept;
    logic                        take;
    logic                        level;
    logic [bgd_pkg::TIME_W-1:0]  now;
    logic                        stable;
    logic [7:0]                  result;
    bgd_pkg::t_deb_status        deb_status;
    bgd_pkg::t_gest_ctl          gest_ctl;
    bgd_pkg::t_gest_event        gest_event;

    assign level         = s_axis_tdata[0];
    assign now           = s_axis_tdata[32:1];
    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign take          = r_out_valid && m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign o_cfg_ready   = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms   <= bgd_pkg::DEBOUNCE_RST;
            r_long_press_ms <= bgd_pkg::LONG_PRESS_RST;
            r_click_gap_ms  <= bgd_pkg::CLICK_GAP_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == bgd_pkg::CFG_DEBOUNCE) begin
                r_debounce_ms <= i_cfg_data;
            end
            if (i_cfg_index == bgd_pkg::CFG_LONG_PRESS) begin
                r_long_press_ms <= i_cfg_data;
            end
            if (i_cfg_index == bgd_pkg::CFG_CLICK_GAP) begin
                r_click_gap_ms <= i_cfg_data;
            end
        end
    end

    bgd_debounce u_debounce (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_level       (level),
        .i_now         (now),
        .i_debounce_ms (r_debounce_ms),
        .i_ctl         (gest_ctl),
        .o_status      (deb_status),
        .o_stable      (stable)
    );

    bgd_fsm u_fsm (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_now           (now),
        .i_long_press_ms (r_long_press_ms),
        .i_click_gap_ms  (r_click_gap_ms),
        .i_status        (deb_status),
        .o_ctl           (gest_ctl),
        .o_event         (gest_event)
    );

    assign result = {4'b0000, stable, gest_event};

    // Output register with a one-word skid stage behind it.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = accept;
                n_out_data  = result;
            end
        end else if (accept) begin
            n_skid_valid = 1'b1;
            n_skid_data  = result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    // The skid stage only holds a word behind a waiting output word.
    a_skid_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with an empty output register");

    // A word accepted against a stalled output lands in the skid stage.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_out_valid && !m_axis_tready) |=> r_skid_valid)
        else $error("accepted word lost behind a stalled output");

    // The skid word moves forward as soon as the output word is taken.
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && take) |=> (r_out_valid && r_out_data == $past(r_skid_data)))
        else $error("skid word not forwarded after the output was taken");

endmodule

`default_nettype wire

[hdl/bgd_debounce.sv]
// ----------------------------------------------------------------------------
// Button gesture detector debouncer
// Accepts a raw level once it has held unchanged for the debounce time and
// clears its stored levels when the gesture machine ends a gesture.
// ----------------------------------------------------------------------------
`default_nettype none

module bgd_debounce (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_accept,
    input  wire                                i_level,
    input  wire  [bgd_pkg::TIME_W-1:0]         i_now,
    input  wire  [bgd_pkg::CFG_W-1:0]          i_debounce_ms,
    input  bgd_pkg::t_gest_ctl                 i_ctl,
    output bgd_pkg::t_deb_status               o_status,
    output logic                               o_stable
);

    logic                        r_raw;
    logic                        r_deb;
    logic [bgd_pkg::TIME_W-1:0]  r_change;
    logic                        n_raw;
    logic                        n_deb;
    logic [bgd_pkg::TIME_W-1:0]  n_change;
    logic [bgd_pkg::TIME_W-1:0]  elapsed;
    logic                        same;
    logic                        deb_pre;

    // Level filter: take the raw level once it has held long enough.
    always_comb begin
        same     = (r_raw == i_level);
        elapsed  = i_now - r_change;
        deb_pre  = (same && (elapsed >= {{(bgd_pkg::TIME_W-bgd_pkg::CFG_W){1'b0}},
                                         i_debounce_ms})) ? i_level : r_deb;
        n_change = same ? r_change : i_now;
        n_raw    = i_ctl.clear ? 1'b0 : i_level;
        n_deb    = i_ctl.clear ? 1'b0 : deb_pre;
    end

    assign o_status.pressed = deb_pre;
    assign o_stable         = n_deb;

    // State registers advance once per accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw    <= 1'b0;
            r_deb    <= 1'b0;
            r_change <= '0;
        end else if (i_accept) begin
            r_raw    <= n_raw;
            r_deb    <= n_deb;
            r_change <= n_change;
        end
    end

    // A level change always restarts the hold timer.
    a_change_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_ctl.clear && (r_raw != i_level)) |=> (r_change == $past(i_now)))
        else $error("hold timer not restarted on a level change");

    // A cleared gesture leaves both stored levels low.
    a_clear_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_ctl.clear) |=> (!r_raw && !r_deb))
        else $error("stored levels not cleared at the end of a gesture");

endmodule

`default_nettype wire

[hdl/bgd_fsm.sv]
// ----------------------------------------------------------------------------
// Button gesture detector state machine
// Tracks press, release and click phases from the debounced level and
// reports one event per word.
// ----------------------------------------------------------------------------
`default_nettype none

module bgd_fsm (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_accept,
    input  wire  [bgd_pkg::TIME_W-1:0]         i_now,
    input  wire  [bgd_pkg::CFG_W-1:0]          i_long_press_ms,
    input  wire  [bgd_pkg::CFG_W-1:0]          i_click_gap_ms,
    input  bgd_pkg::t_deb_status               i_status,
    output bgd_pkg::t_gest_ctl                 o_ctl,
    output bgd_pkg::t_gest_event               o_event
);

    bgd_pkg::t_gest_state        r_state;
    bgd_pkg::t_gest_state        n_state;
    logic [bgd_pkg::TIME_W-1:0]  r_phase;
    logic [bgd_pkg::TIME_W-1:0]  n_phase;
    logic [bgd_pkg::CNT_W-1:0]   r_count;
    logic [bgd_pkg::CNT_W-1:0]   n_count;
    logic [bgd_pkg::TIME_W-1:0]  wait_ms;
    logic                        long_hit;
    logic                        gap_hit;
    logic                        count_done;
    logic                        pressed;

    // Phase timing compares.
    always_comb begin
        pressed    = i_status.pressed;
        wait_ms    = i_now - r_phase;
        long_hit   = wait_ms > {{(bgd_pkg::TIME_W-bgd_pkg::CFG_W){1'b0}}, i_long_press_ms};
        gap_hit    = wait_ms >= {{(bgd_pkg::TIME_W-bgd_pkg::CFG_W){1'b0}}, i_click_gap_ms};
        count_done = gap_hit || (r_count == bgd_pkg::CNT_DOUBLE);
    end

    // Next state, phase start and click count.
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_count     = r_count;
        o_ctl.clear = 1'b0;
        unique case (r_state)
            bgd_pkg::ST_IDLE: begin
                if (pressed) begin
                    n_state = bgd_pkg::ST_DOWN;
                    n_phase = i_now;
                    n_count = '0;
                end
            end
            bgd_pkg::ST_DOWN: begin
                if (!pressed) begin
                    n_state = bgd_pkg::ST_UP;
                    n_phase = i_now;
                end else if (long_hit) begin
                    n_state = bgd_pkg::ST_HELD;
                end
            end
            bgd_pkg::ST_UP: begin
                if (r_count != bgd_pkg::CNT_MAX) begin
                    n_count = r_count + 1'b1;
                end
                n_state = bgd_pkg::ST_COUNT;
            end
            bgd_pkg::ST_COUNT: begin
                if (pressed) begin
                    n_state = bgd_pkg::ST_DOWN;
                    n_phase = i_now;
                end else if (count_done) begin
                    o_ctl.clear = 1'b1;
                end
            end
            bgd_pkg::ST_HELD: begin
                if (!pressed) begin
                    n_state = bgd_pkg::ST_RELEASED;
                    n_phase = i_now;
                end
            end
            bgd_pkg::ST_RELEASED: begin
                o_ctl.clear = 1'b1;
            end
            default: begin
                n_state = bgd_pkg::ST_IDLE;
            end
        endcase
        // The end of a gesture returns everything to its idle values.
        if (o_ctl.clear) begin
            n_state = bgd_pkg::ST_IDLE;
            n_phase = '0;
            n_count = '0;
        end
    end

    // Event output.
    always_comb begin
        o_event = bgd_pkg::EV_NONE;
        unique case (r_state)
            bgd_pkg::ST_DOWN: begin
                if (pressed && long_hit) begin
                    o_event = bgd_pkg::EV_LONG;
                end
            end
            bgd_pkg::ST_COUNT: begin
                if (!pressed && count_done) begin
                    if (r_count == bgd_pkg::CNT_SINGLE) begin
                        o_event = bgd_pkg::EV_CLICK;
                    end else if (r_count == bgd_pkg::CNT_DOUBLE) begin
                        o_event = bgd_pkg::EV_DOUBLE;
                    end
                end
            end
            bgd_pkg::ST_RELEASED: begin
                o_event = bgd_pkg::EV_LONG_REL;
            end
            default: begin
                o_event = bgd_pkg::EV_NONE;
            end
        endcase
    end

    // State registers advance once per accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bgd_pkg::ST_IDLE;
            r_phase <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // A click or double click report always ends the gesture.
    a_click_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (o_event == bgd_pkg::EV_CLICK || o_event == bgd_pkg::EV_DOUBLE))
        |=> (r_state == bgd_pkg::ST_IDLE && r_count == '0))
        else $error("click report did not end the gesture");

    // Long press start moves the machine to the held state.
    a_long_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_event == bgd_pkg::EV_LONG) |=> (r_state == bgd_pkg::ST_HELD))
        else $error("long press start without entering the held state");

    // Counting a release never leaves the click count at zero.
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_state == bgd_pkg::ST_UP) |=> (r_count != '0))
        else $error("release was not counted");

endmodule

`default_nettype wire
